// ===== hdl/length_prefixed_frame_hunter_defines.svh =====
// Assertion helpers shared by the frame hunter modules.
// Each expects clk and arst_n in scope.
`ifndef LENGTH_PREFIXED_FRAME_HUNTER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_HUNTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LPFH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lpfh_pkg.sv =====
`default_nettype none
package lpfh_pkg;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 11;
	localparam int WIN_W  = 24;
	localparam int CNT_W  = 2;

	// largest length an 11-bit limit can name
	localparam int LEN_MAX = 2047;

	localparam int MAX_PAYLOAD_DFLT = 1024;
	localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(1024);

	// header window holds three bytes; the fourth completes the length
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(3);

	typedef struct packed {
		logic [BYTE_W-1:0] rx_data;
		logic              lost_before;
	} lpfh_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              is_first;
		logic              is_last;
		logic              aborted;
	} lpfh_res_t;

endpackage
`default_nettype wire

// ===== hdl/lpfh_ifs.sv =====
`default_nettype none
interface lpfh_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_data;
	logic       lost_before;

	modport source (output valid, rx_data, lost_before, input ready);
	modport sink (input valid, rx_data, lost_before, output ready);
endinterface

interface lpfh_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       is_first;
	logic       is_last;
	logic       aborted;

	modport source (output valid, payload_byte, is_first, is_last, aborted, input ready);
	modport sink (input valid, payload_byte, is_first, is_last, aborted, output ready);
endinterface
`default_nettype wire

// ===== hdl/lpfh_in_stage.sv =====
`default_nettype none
module lpfh_in_stage import lpfh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire lpfh_item_t in_item,
	input  wire logic       out_free,
	output logic            fire,
	output lpfh_item_t      item_s1
);

	logic valid_s1;

	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpfh_hunt.sv =====
`default_nettype none
`include "length_prefixed_frame_hunter_defines.svh"
module lpfh_hunt import lpfh_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DFLT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [LEN_W-1:0] max_len,
	input  wire logic             fire,
	input  wire lpfh_item_t       item_s1,
	output logic                  res_valid,
	output lpfh_res_t             res
);

	localparam int LEN_CAP = (MAX_PAYLOAD > LEN_MAX) ? LEN_MAX : MAX_PAYLOAD;
	localparam int LEFT_W  = $clog2(LEN_CAP + 1);
	localparam logic [LEN_W-1:0] CAP_L = LEN_W'(LEN_CAP);

	logic [WIN_W-1:0]  win_q,  win_d;
	logic [CNT_W-1:0]  cnt_q,  cnt_d;
	logic [LEFT_W-1:0] left_q, left_d;
	logic              start_q, start_d;

	logic [LEN_W-1:0]  lim;
	logic [WIN_W-1:0]  hw;      // window the hunt step starts from
	logic [CNT_W-1:0]  hc;
	logic              len_ok;
	logic [BYTE_W-1:0] b;

	assign b   = item_s1.rx_data;
	assign lim = (max_len > CAP_L) ? CAP_L : max_len;

	// loss discards any partial header before the hunt step
	assign hw = item_s1.lost_before ? '0 : win_q;
	assign hc = item_s1.lost_before ? '0 : cnt_q;

	// length = {b, hw}; nonzero and not above the limit
	assign len_ok = (b == '0) && (hw[WIN_W-1:LEN_W] == '0) &&
		(hw[LEN_W-1:0] != '0) && (hw[LEN_W-1:0] <= lim);

	always_comb begin
		win_d     = win_q;
		cnt_d     = cnt_q;
		left_d    = left_q;
		start_d   = start_q;
		res_valid = 1'b0;
		res       = '0;
		if (item_s1.lost_before || left_q == '0) begin
			if (item_s1.lost_before && left_q != '0) begin
				res_valid   = 1'b1;
				res.aborted = 1'b1;
			end
			left_d  = '0;
			start_d = item_s1.lost_before ? 1'b0 : start_q;
			win_d   = hw;
			cnt_d   = hc;
			if (hc != CNT_FULL) begin
				case (hc)
					CNT_W'(0): win_d[7:0]   = hw[7:0] | b;
					CNT_W'(1): win_d[15:8]  = hw[15:8] | b;
					CNT_W'(2): win_d[23:16] = hw[23:16] | b;
					default:   win_d        = hw;
				endcase
				cnt_d = hc + CNT_W'(1);
			end else if (len_ok) begin
				left_d  = hw[LEFT_W-1:0];
				start_d = 1'b1;
				win_d   = '0;
				cnt_d   = '0;
			end else begin
				win_d = {b, hw[WIN_W-1:8]};
			end
		end else begin
			res_valid        = 1'b1;
			res.payload_byte = b;
			res.is_first     = start_q;
			res.is_last      = (left_q == LEFT_W'(1));
			left_d           = left_q - LEFT_W'(1);
			start_d          = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			start_q <= 1'b0;
		end else if (fire) begin
			win_q   <= win_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			start_q <= start_d;
		end
	end

	`LPFH_ASSERT_NOW(a_no_header_in_payload, left_q != '0, cnt_q == '0 && win_q == '0, "header bytes held during payload")
	`LPFH_ASSERT_NOW(a_start_needs_payload, start_q, left_q != '0, "frame start flag without payload")
	`LPFH_ASSERT_NOW(a_left_in_range, 1'b1, left_q <= LEFT_W'(LEN_CAP), "payload count above cap")

endmodule
`default_nettype wire

// ===== hdl/lpfh_out_reg.sv =====
`default_nettype none
`include "length_prefixed_frame_hunter_defines.svh"
module lpfh_out_reg import lpfh_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      load,
	input  wire lpfh_res_t res,
	input  wire logic      out_ready,
	output logic           out_valid,
	output logic           out_free,
	output lpfh_res_t      res_q
);

	logic valid_q;

	assign out_valid = valid_q;
	assign out_free  = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	`LPFH_ASSERT_NOW(a_no_overwrite, load, out_free, "result loaded over a pending beat")
	`LPFH_ASSERT_NEXT(a_load_shows, load, valid_q, "loaded result not presented")
	`LPFH_ASSERT_NEXT(a_stall_hold, valid_q && !out_ready, valid_q && $stable(res_q), "beat lost")

endmodule
`default_nettype wire

// ===== hdl/length_prefixed_frame_hunter.sv =====
// Length-prefixed frame hunter.
// rx (sink): one received byte per beat, with lost_before set when bytes
//   were dropped just ahead of it. valid/ready, beat taken when both high.
// frame (source): one beat per payload byte, is_first/is_last marking the
//   frame ends; a single beat with aborted set (byte and marks zero) when
//   a loss cuts a frame short. Header bytes give no beat.
// cfg_we/cfg_wdata: writes max_len, the largest accepted length; values
//   above MAX_PAYLOAD act as MAX_PAYLOAD. Write only while idle.
// Path: a byte taken on rx passes the input register, then the state
//   update into the output register, before it shows on frame.
// Throughput: one byte per cycle while frame.ready is high; the only loop
//   is the hunt state update, and rx.ready stays high while frame is draining.
// Stall: when frame.ready is low with a beat pending, the input register
//   holds one more byte and then rx.ready drops; nothing is lost.
// Reset: arst_n clears the hunt state, the pending beats and sets max_len
//   to 1024; the block is ready right after reset is released.
`default_nettype none
module length_prefixed_frame_hunter import lpfh_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DFLT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata,
	lpfh_rx_if.sink               rx,
	lpfh_frame_if.source          frame
);

	logic [LEN_W-1:0] max_len_q;
	lpfh_item_t       in_item;
	lpfh_item_t       item_s1;
	logic             fire;
	logic             out_free;
	logic             res_valid;
	lpfh_res_t        res;
	lpfh_res_t        res_q;

	// limit register; the user writes it between frames, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

	assign in_item.rx_data     = rx.rx_data;
	assign in_item.lost_before = rx.lost_before;

	// stage 1: byte register
	lpfh_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_item  (in_item),
		.out_free (out_free),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	// hunt/payload state, updated once per byte leaving stage 1
	lpfh_hunt #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_hunt (
		.clk       (clk),
		.arst_n    (arst_n),
		.max_len   (max_len_q),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// stage 2: result register toward the frame channel
	lpfh_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.res       (res),
		.out_ready (frame.ready),
		.out_valid (frame.valid),
		.out_free  (out_free),
		.res_q     (res_q)
	);

	assign frame.payload_byte = res_q.payload_byte;
	assign frame.is_first     = res_q.is_first;
	assign frame.is_last      = res_q.is_last;
	assign frame.aborted      = res_q.aborted;

endmodule
`default_nettype wire
